@@ rtl/boolean_cover_subset_search_defines.svh @@
// ----------------------------------------------------------------------------
// Boolean cover subset search: assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef BOOLEAN_COVER_SUBSET_SEARCH_DEFINES_SVH
`define BOOLEAN_COVER_SUBSET_SEARCH_DEFINES_SVH

// a in one cycle implies b in the next cycle
`define BCSS_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle property failed");

// a implies b in the same cycle
`define BCSS_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("same-cycle property failed");

// cond never holds
`define BCSS_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ rtl/bcss_pkg.sv @@
// ----------------------------------------------------------------------------
// bcss_pkg
// Types, constants and helpers shared by the subset search block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcss_pkg;

  localparam int MAX_BASIS_C = 8;
  localparam int MAX_DIM_C   = 64;
  localparam int VEC_W       = 64;
  localparam int MASK_W      = 8;
  localparam int ERR_W       = 14;
  localparam int IDX_W       = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int DIM_W       = 7;
  localparam int COUNT_W     = 4;
  localparam int PEN_W       = 8;
  localparam int ERR_MAX     = 255 * 64;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic {
    CMD_LOAD,
    CMD_QUERY
  } cmd_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PENALTY_ONE,
    REG_PENALTY_ZERO,
    REG_BASIS_COUNT,
    REG_DIMENSION
  } cfg_reg_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [IDX_W-1:0] index;
    logic [VEC_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic [PEN_W-1:0]   penalty_one;
    logic [PEN_W-1:0]   penalty_zero;
    logic [COUNT_W-1:0] basis_count;
    logic [DIM_W-1:0]   dimension;
  } cfg_t;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] d,
                                               input logic [DIM_W-1:0] lim);
    return (d > lim) ? lim : d;
  endfunction

  function automatic logic [VEC_W-1:0] low_mask(input logic [DIM_W-1:0] bits);
    logic [VEC_W-1:0] m;
    m = '0;
    for (int k = 0; k < VEC_W; k++) begin
      m[k] = (DIM_W'(k) < bits);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bcss_front.sv @@
// ----------------------------------------------------------------------------
// bcss_front
// Accepts input beats, drops loads aimed past the store, trims query rows
// to the active dimension and hands commands to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcss_front
  import bcss_pkg::*;
#(
  parameter int MAX_BASIS = MAX_BASIS_C,
  parameter int MAX_DIM   = MAX_DIM_C
) (
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             opcode,
  input  wire logic [IDX_W-1:0] basis_index,
  input  wire logic [VEC_W-1:0] vector_bits,
  input  wire logic [DIM_W-1:0] dimension,
  input  wire logic             q_ready,
  output logic                  push,
  output cmd_t                  cmd
);

  logic             is_query;
  logic             keep;
  logic [DIM_W-1:0] dim_eff;

  assign is_query = (opcode == OP_QUERY);
  assign keep     = is_query || ({1'b0, basis_index} < (IDX_W + 1)'(MAX_BASIS));
  assign dim_eff  = sat_dim(dimension, DIM_W'(MAX_DIM));

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready && keep;

  always_comb begin
    cmd.kind  = is_query ? CMD_QUERY : CMD_LOAD;
    cmd.index = basis_index;
    cmd.data  = is_query ? (vector_bits & low_mask(dim_eff)) : vector_bits;
  end

endmodule

`default_nettype wire

@@ rtl/bcss_queue.sv @@
// ----------------------------------------------------------------------------
// bcss_queue
// Short command queue between the front and the search engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcss_queue
  import bcss_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      ready,
  input  wire logic pop,
  output logic      valid,
  output cmd_t      head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign ready   = (count != CW'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/bcss_back.sv @@
// ----------------------------------------------------------------------------
// bcss_back
// Holds the basis store and runs the subset search: one subset enters a
// four-stage score pipeline each cycle, the last stage keeps the minimum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcss_back
  import bcss_pkg::*;
#(
  parameter int MAX_BASIS = MAX_BASIS_C,
  parameter int MAX_DIM   = MAX_DIM_C
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  cfg_t                   cfg,
  input  wire logic              q_valid,
  input  cmd_t                   q_head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [MASK_W-1:0]      best_mask,
  output logic [ERR_W-1:0]       min_error
);

  localparam int IW = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1;
  localparam int CW = $clog2(MAX_DIM + 1);
  localparam int EW = PEN_W + CW + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_t;

  state_t                 state;
  logic [MAX_DIM-1:0]     store [MAX_BASIS];
  logic [MAX_DIM-1:0]     data_q;
  logic [MAX_BASIS-1:0]   subset;
  logic [MAX_BASIS-1:0]   last;
  logic [COUNT_W-1:0]     nb;
  logic [MAX_DIM-1:0]     dmask;
  logic [MAX_DIM-1:0]     uni;
  logic                   have;
  logic [EW-1:0]          best_e;
  logic [MAX_BASIS-1:0]   best_s;

  logic                   v1, v2, v3;
  logic [MAX_BASIS-1:0]   m1, m2, m3;
  logic [MAX_DIM-1:0]     cov1, unc1;
  logic [CW-1:0]          cov2, unc2;
  logic [EW-1:0]          e3;
  logic                   better;
  logic                   empty;

  function automatic logic [CW-1:0] ones_in(input logic [MAX_DIM-1:0] x);
    logic [CW-1:0] n;
    n = '0;
    for (int k = 0; k < MAX_DIM; k++) begin
      n = n + CW'(x[k]);
    end
    return n;
  endfunction

  assign nb    = (cfg.basis_count > COUNT_W'(MAX_BASIS)) ? COUNT_W'(MAX_BASIS)
                                                         : cfg.basis_count;
  assign last  = ~({MAX_BASIS{1'b1}} << nb);
  assign dmask = MAX_DIM'(low_mask(sat_dim(cfg.dimension, DIM_W'(MAX_DIM))));
  assign pop   = (state == S_IDLE) && q_valid;
  assign empty = !v1 && !v2 && !v3;
  assign better = v3 && (!have || (e3 < best_e));

  always_comb begin
    uni = '0;
    for (int i = 0; i < MAX_BASIS; i++) begin
      if (subset[i]) begin
        uni = uni | store[i];
      end
    end
    uni = uni & dmask;
  end

  always_ff @(posedge clk) begin
    if (pop && (q_head.kind == CMD_LOAD)) begin
      store[q_head.index[IW-1:0]] <= q_head.data[MAX_DIM-1:0];
    end
    if (pop && (q_head.kind == CMD_QUERY)) begin
      data_q <= q_head.data[MAX_DIM-1:0];
    end
  end

  always_ff @(posedge clk) begin
    m1   <= subset;
    cov1 <= uni & ~data_q;
    unc1 <= data_q & ~uni;
    m2   <= m1;
    cov2 <= ones_in(cov1);
    unc2 <= ones_in(unc1);
    m3   <= m2;
    e3   <= (EW'(cfg.penalty_zero) * EW'(cov2)) + (EW'(cfg.penalty_one) * EW'(unc2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      subset    <= '0;
      have      <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= (state == S_RUN);
      v2 <= v1;
      v3 <= v2;
      if (better) begin
        have   <= 1'b1;
        best_e <= e3;
        best_s <= m3;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop && (q_head.kind == CMD_QUERY)) begin
            subset <= '0;
            have   <= 1'b0;
            state  <= S_RUN;
          end
        end
        S_RUN: begin
          if (subset == last) begin
            state <= S_DRAIN;
          end else begin
            subset <= subset + 1'b1;
          end
        end
        S_DRAIN: begin
          if (empty && (!out_valid || out_ready)) begin
            out_valid <= 1'b1;
            best_mask <= MASK_W'(best_s);
            min_error <= ERR_W'(best_e);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/boolean_cover_subset_search.sv @@
// ----------------------------------------------------------------------------
// boolean_cover_subset_search
// Top level: configuration registers, front, command queue, search engine.
// ----------------------------------------------------------------------------
// Input beats (in_valid/in_ready) carry opcode, basis_index and vector_bits.
// A load beat writes one basis row and gives no result; a query beat gives
// one result beat (out_valid/out_ready) with best_mask and min_error.
// Configuration beats (cfg_valid/cfg_ready, cfg_index, cfg_data) set
// penalty_one, penalty_zero, basis_count and dimension; cfg_ready is always
// high. Write configuration only while no query is in flight.
// A query's search covers all 2^n subsets, n being basis_count capped at 8:
// the search engine scores one subset per cycle through a four-stage
// pipeline, and takes the next query only once the last result is in the
// output register. A load passes through the queue and writes its row in the
// cycle after acceptance when the engine is idle. A two-entry command queue
// takes beats while the engine is busy; in_ready drops when it is full.
// The result sits in an output register; while the receiver stalls, loads
// still proceed and the next query waits at its final stage.
// Reset clears control state and sets the registers to their defaults;
// basis rows hold no defined value until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module boolean_cover_subset_search
  import bcss_pkg::*;
#(
  parameter int MAX_BASIS = MAX_BASIS_C,
  parameter int MAX_DIM   = MAX_DIM_C
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  opcode,
  input  wire logic [IDX_W-1:0]      basis_index,
  input  wire logic [VEC_W-1:0]      vector_bits,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [MASK_W-1:0]          best_mask,
  output logic [ERR_W-1:0]           min_error,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  logic q_ready;
  logic q_valid;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.penalty_one  <= PEN_W'(1);
      cfg.penalty_zero <= PEN_W'(1);
      cfg.basis_count  <= COUNT_W'(8);
      cfg.dimension    <= DIM_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PENALTY_ONE:  cfg.penalty_one  <= cfg_data;
        REG_PENALTY_ZERO: cfg.penalty_zero <= cfg_data;
        REG_BASIS_COUNT:  cfg.basis_count  <= cfg_data[COUNT_W-1:0];
        REG_DIMENSION:    cfg.dimension    <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  bcss_front #(
    .MAX_BASIS (MAX_BASIS),
    .MAX_DIM   (MAX_DIM)
  ) u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .basis_index (basis_index),
    .vector_bits (vector_bits),
    .dimension   (cfg.dimension),
    .q_ready     (q_ready),
    .push        (push),
    .cmd         (push_cmd)
  );

  bcss_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .ready    (q_ready),
    .pop      (pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  bcss_back #(
    .MAX_BASIS (MAX_BASIS),
    .MAX_DIM   (MAX_DIM)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .best_mask  (best_mask),
    .min_error  (min_error)
  );

endmodule

`default_nettype wire

@@ rtl/bcss_checker.sv @@
// ----------------------------------------------------------------------------
// bcss_checker
// Port-level checks on the subset search block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "boolean_cover_subset_search_defines.svh"

module bcss_checker
  import bcss_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [MASK_W-1:0] best_mask,
  input wire logic [ERR_W-1:0]  min_error,
  input wire logic              cfg_ready
);

  logic [MASK_W+ERR_W-1:0] out_beat;

  assign out_beat = {best_mask, min_error};

  `BCSS_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_beat))
  `BCSS_NEXT(a_out_clear, clk, 1'b0, rst, !out_valid)
  `BCSS_IMPLY(a_err_bound, clk, rst, out_valid, min_error <= ERR_W'(ERR_MAX))
  `BCSS_NEVER(a_cfg_ready, clk, rst, !cfg_ready)

endmodule

bind boolean_cover_subset_search bcss_checker u_bcss_checker (.*);

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: boolean cover subset search testbench
// Loads basis rows, runs queries under many register settings and checks
// each result beat against an in-bench prediction of the best subset mask
// and its weighted error. Both channels see random idle bursts, a long
// receiver hold-off and a quiet tail without idling.
// ----------------------------------------------------------------------------

module tb;
  import bcss_pkg::*;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic [ERR_W-1:0]  err;
  } cover_result_t;

  localparam int SETTLE_CYCLES = 300;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  opcode = 1'b0;
  logic [IDX_W-1:0]      basis_index = '0;
  logic [VEC_W-1:0]      vector_bits = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [MASK_W-1:0]     best_mask;
  logic [ERR_W-1:0]      min_error;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [VEC_W-1:0]   shadow_rows [MAX_BASIS_C];
  logic [PEN_W-1:0]   pen_one = 8'd1;
  logic [PEN_W-1:0]   pen_zero = 8'd1;
  logic [COUNT_W-1:0] use_count = 4'd8;
  logic [DIM_W-1:0]   use_dim = 7'd64;

  cover_result_t pending_covers [$];
  int            mismatches = 0;
  bit            src_idle_on = 1'b1;
  bit            sink_idle_on = 1'b1;
  int            hold_req = 0;

  always #6 clk = ~clk;

  boolean_cover_subset_search i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .basis_index(basis_index),
    .vector_bits(vector_bits),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .best_mask  (best_mask),
    .min_error  (min_error),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  function automatic cover_result_t predict_cover(input logic [VEC_W-1:0] data_row);
    int unsigned      nb;
    int unsigned      dim;
    int unsigned      e;
    int unsigned      best_e;
    logic [VEC_W-1:0] keep;
    logic [VEC_W-1:0] d;
    logic [VEC_W-1:0] u;
    logic [MASK_W-1:0] best_s;
    cover_result_t    r;
    nb = (use_count > MAX_BASIS_C) ? MAX_BASIS_C : use_count;
    dim = (use_dim > MAX_DIM_C) ? MAX_DIM_C : use_dim;
    keep = (dim >= 64) ? '1 : ((64'(1) << dim) - 64'(1));
    d = data_row & keep;
    best_e = 0;
    best_s = '0;
    for (int s = 0; s < (1 << nb); s++) begin
      u = '0;
      for (int i = 0; i < nb; i++) begin
        if (s[i]) u |= shadow_rows[i];
      end
      u &= keep;
      e = int'(pen_zero) * $countones(u & ~d) + int'(pen_one) * $countones(d & ~u);
      if (s == 0 || e < best_e) begin
        best_e = e;
        best_s = s[MASK_W-1:0];
      end
    end
    r.mask = best_s;
    r.err = best_e[ERR_W-1:0];
    return r;
  endfunction

  function automatic logic [VEC_W-1:0] rand_row();
    logic [VEC_W-1:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: r = '0;
      1: r = '1;
      2, 3: r &= {$urandom, $urandom} & {$urandom, $urandom};
      4: r |= {$urandom, $urandom};
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [VEC_W-1:0] near_cover_row();
    logic [VEC_W-1:0] r;
    r = '0;
    for (int k = 0; k < MAX_BASIS_C; k++) begin
      if ($urandom_range(0, 2) == 0) r |= shadow_rows[k];
    end
    case ($urandom_range(0, 5))
      0: ;
      1, 2: r ^= {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      3: r ^= 64'(1) << $urandom_range(0, 63);
      default: r = rand_row();
    endcase
    return r;
  endfunction

  function automatic logic [PEN_W-1:0] pick_penalty();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic send_beat(input op_t op, input logic [IDX_W-1:0] idx,
                           input logic [VEC_W-1:0] vec);
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    basis_index <= idx;
    vector_bits <= vec;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_QUERY) pending_covers.push_back(predict_cover(vec));
    else shadow_rows[idx] = vec;
  endtask

  task automatic random_beat();
    if ($urandom_range(0, 2) == 0) send_beat(OP_LOAD, 3'($urandom), rand_row());
    else send_beat(OP_QUERY, 3'($urandom), near_cover_row());
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_covers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (r)
      REG_PENALTY_ONE:  pen_one = v;
      REG_PENALTY_ZERO: pen_zero = v;
      REG_BASIS_COUNT:  use_count = v[COUNT_W-1:0];
      REG_DIMENSION:    use_dim = v[DIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_search(input logic [7:0] p1, input logic [7:0] p0,
                                input logic [7:0] bc, input logic [7:0] dim);
    wait_drain();
    write_reg(REG_PENALTY_ONE, p1);
    write_reg(REG_PENALTY_ZERO, p0);
    write_reg(REG_BASIS_COUNT, bc);
    write_reg(REG_DIMENSION, dim);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_default_config();
    send_beat(OP_LOAD, 3'd0, '0);
    send_beat(OP_LOAD, 3'd1, 64'hFFFF_FFFF_0000_0000);
    send_beat(OP_LOAD, 3'd2, 64'h0000_0000_FFFF_FFFF);
    send_beat(OP_LOAD, 3'd3, 64'hAAAA_AAAA_AAAA_AAAA);
    send_beat(OP_LOAD, 3'd4, 64'h5555_5555_5555_5555);
    send_beat(OP_LOAD, 3'd5, 64'h0F0F_0F0F_0F0F_0F0F);
    send_beat(OP_LOAD, 3'd6, {$urandom, $urandom});
    send_beat(OP_LOAD, 3'd7, '1);
    send_beat(OP_QUERY, 3'd0, '0);
    send_beat(OP_QUERY, 3'd7, '1);
    send_beat(OP_QUERY, 3'($urandom), shadow_rows[1] | shadow_rows[4]);
    send_beat(OP_QUERY, 3'($urandom), 64'h8000_0000_0000_0001);
  endtask

  task automatic test_penalty_extremes();
    program_search(8'd0, 8'd0, 8'd4, 8'd64);
    send_beat(OP_QUERY, 3'($urandom), rand_row());
    program_search(8'd255, 8'd255, 8'd4, 8'd64);
    send_beat(OP_QUERY, 3'($urandom), near_cover_row());
    program_search(8'd255, 8'd0, 8'd4, 8'd64);
    send_beat(OP_QUERY, 3'($urandom), 64'h0123_4567_89AB_CDEF);
    program_search(8'd0, 8'd255, 8'd4, 8'd64);
    send_beat(OP_QUERY, 3'($urandom), 64'hFEDC_BA98_7654_3210);
  endtask

  task automatic test_basis_count_edges();
    program_search(8'd1, 8'd1, 8'd0, 8'd64);
    send_beat(OP_QUERY, 3'($urandom), '1);
    program_search(8'd1, 8'd1, 8'd1, 8'd64);
    send_beat(OP_QUERY, 3'($urandom), 64'hFFFF_FFFF_0000_0001);
    program_search(8'd3, 8'd2, 8'hFF, 8'd64);
    send_beat(OP_QUERY, 3'($urandom), near_cover_row());
    program_search(8'd2, 8'd5, 8'hF2, 8'd64);
    send_beat(OP_QUERY, 3'($urandom), near_cover_row());
  endtask

  task automatic test_dimension_edges();
    program_search(8'd7, 8'd9, 8'd4, 8'd0);
    send_beat(OP_QUERY, 3'($urandom), '1);
    program_search(8'd1, 8'd1, 8'd4, 8'd1);
    send_beat(OP_LOAD, 3'd0, 64'hFFFF_FFFF_FFFF_FFFE);
    send_beat(OP_QUERY, 3'($urandom), 64'h0000_0000_0000_0001);
    send_beat(OP_QUERY, 3'($urandom), 64'hFFFF_FFFF_FFFF_FFFE);
    program_search(8'd2, 8'd3, 8'hFF, 8'hFF);
    send_beat(OP_QUERY, 3'($urandom), near_cover_row());
    program_search(8'd1, 8'd1, 8'd4, 8'hBF);
    send_beat(OP_QUERY, 3'($urandom), '1);
  endtask

  task automatic test_backpressure();
    program_search(8'd1, 8'd1, 8'd2, 8'd64);
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    hold_req = 400;
    repeat (24) send_beat(OP_QUERY, 3'($urandom), near_cover_row());
    wait_drain();
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  task automatic test_random_phases(input int phases);
    logic [3:0] bc;
    logic [6:0] dim;
    for (int ph = 0; ph < phases; ph++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: bc = 4'($urandom_range(0, 4));
        6, 7, 8: bc = 4'($urandom_range(5, 8));
        default: bc = 4'($urandom_range(9, 15));
      endcase
      case ($urandom_range(0, 9))
        0: dim = 7'd0;
        1: dim = 7'd64;
        2: dim = 7'($urandom_range(65, 127));
        default: dim = 7'($urandom_range(1, 64));
      endcase
      program_search(pick_penalty(), pick_penalty(), {4'($urandom), bc},
                     {1'($urandom), dim});
      repeat (65) random_beat();
    end
  endtask

  task automatic test_quiet_tail();
    program_search(pick_penalty(), pick_penalty(), 8'd3, 8'd64);
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    repeat (60) random_beat();
  endtask

  initial begin
    cover_result_t want;
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_covers.size() == 0) begin
          report_mismatch($sformatf("unexpected beat mask %0h error %0d",
                                    best_mask, min_error));
        end else begin
          want = pending_covers.pop_front();
          if (best_mask !== want.mask)
            report_mismatch($sformatf("best_mask %0h, want %0h", best_mask, want.mask));
          if (min_error !== want.err)
            report_mismatch($sformatf("min_error %0d, want %0d", min_error, want.err));
        end
      end
      if (hold_req > 0) begin
        out_ready <= 1'b0;
        hold_req--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (sink_idle_on && $urandom_range(0, 6) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(1, 18) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_config();
    test_penalty_extremes();
    test_basis_count_edges();
    test_dimension_edges();
    test_backpressure();
    test_random_phases(13);
    test_quiet_tail();
    wait_drain();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/bcss_pkg.sv
rtl/bcss_front.sv
rtl/bcss_queue.sv
rtl/bcss_back.sv
rtl/boolean_cover_subset_search.sv
rtl/bcss_checker.sv
tb/tb.sv
